FILE: rtl/smpb_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum magnitude, peak and band package
// Shared widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package smpb_pkg;

  localparam int MAX_BINS_LOG2 = 10;
  localparam int SAMPLE_WIDTH  = 24;
  localparam int BIN_W         = MAX_BINS_LOG2;
  localparam int MAG_W         = SAMPLE_WIDTH;
  localparam int POW_W         = 2 * SAMPLE_WIDTH;
  localparam int SUM_W         = 58;
  localparam int ROOT_W        = SUM_W / 2;
  localparam int RATE_W        = 18;
  localparam int FREQ_W        = 21;
  localparam int LOG_W         = 4;
  localparam int STEP_W        = $clog2(ROOT_W + 1);
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    REG_BINS_LOG2   = 2'd0,
    REG_SAMPLE_RATE = 2'd1,
    REG_BAND_FIRST  = 2'd2,
    REG_BAND_LAST   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_FREQ,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/smpb_isqrt.sv
// ----------------------------------------------------------------------------
// Serial integer square root
// Restoring digit-by-digit floor root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module smpb_isqrt import smpb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  value,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  val_r, val_nxt;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;

  always_comb begin
    rem_sh   = {rem_r, val_r[SUM_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      val_nxt = {val_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = (ROOT_W + 1)'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = (ROOT_W + 1)'(rem_sh);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/spectrum_magnitude_peak_band_unit.sv
// ----------------------------------------------------------------------------
// Spectrum magnitude, peak and band unit
// FFT bins enter one per transfer on the in_ channel as signed real and
// imaginary parts. Each bin gives one transfer on the out_ channel with its
// index within the frame and the floor root of re^2 + im^2. The transfer for
// the last bin of a frame also carries the peak bin over bins 1..N/2, its
// magnitude and frequency in 1/16 Hz, and the root of the summed band power.
// Both channels use valid/ready. Registers must be written over the APB port
// only while the unit is idle; the unit itself does not enforce this.
// The unit takes no new bin until the previous one has been loaded into the
// output register. Each bin passes the 24-step bit-serial squarer and the
// 29-step root unit that retires two radicand bits per cycle, and the last
// bin of a frame also the 10-step serial multiplier for the peak frequency.
// A finished result sits in the output register until taken. The next bin
// is accepted and worked on meanwhile; it waits in its last step only if the
// previous result has still not been taken.
// Reset clears the frame state and the output valid and restores the
// register defaults; the unit is ready as soon as reset has set it idle.
// ----------------------------------------------------------------------------
module spectrum_magnitude_peak_band_unit import smpb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_re_part,
  input  logic signed [SAMPLE_WIDTH-1:0] in_im_part,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [BIN_W-1:0]        out_bin_index,
  output logic [MAG_W-1:0]        out_bin_magnitude,
  output logic                    out_frame_end,
  output logic [BIN_W-1:0]        out_peak_bin,
  output logic [MAG_W-1:0]        out_peak_magnitude,
  output logic [FREQ_W-1:0]       out_peak_freq_q4,
  output logic [ROOT_W-1:0]       out_band_strength,
  output logic                    out_band_valid,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [SAMPLE_WIDTH-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [SAMPLE_WIDTH-1:0] ma_sr, ma_nxt, mb_sr, mb_nxt;
  logic [SAMPLE_WIDTH:0]   hi_r, hi_nxt;
  logic [SAMPLE_WIDTH-1:0] lo_r, lo_nxt;
  logic [BIN_W-1:0]        idx_r, idx_nxt;
  logic                    last_r, last_nxt;
  logic [BIN_W-1:0]        bin_cnt_r, bin_cnt_nxt;
  logic [BIN_W-1:0]        best_bin_r, best_bin_nxt;
  logic [MAG_W-1:0]        best_mag_r, best_mag_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [BIN_W-1:0]        fm_sr, fm_nxt;
  logic [RATE_W-1:0]       fhi_r, fhi_nxt;
  logic [BIN_W-1:0]        flo_r, flo_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [BIN_W-1:0]        o_idx_r, o_idx_nxt;
  logic [MAG_W-1:0]        o_mag_r, o_mag_nxt;
  logic                    o_end_r, o_end_nxt;
  logic [BIN_W-1:0]        o_pbin_r, o_pbin_nxt;
  logic [MAG_W-1:0]        o_pmag_r, o_pmag_nxt;
  logic [FREQ_W-1:0]       o_freq_r, o_freq_nxt;
  logic [ROOT_W-1:0]       o_band_r, o_band_nxt;
  logic                    o_bval_r, o_bval_nxt;

  logic [LOG_W-1:0]        bins_log2_r;
  logic [RATE_W-1:0]       rate_r;
  logic [BIN_W-1:0]        band_first_r, band_last_r;

  logic [LOG_W-1:0]        eff_l;
  logic [BIN_W:0]          n_full;
  logic [BIN_W-1:0]        n_m1, n_half;
  logic                    band_ok, band_in, peak_hit, can_load, cfg_wr;
  logic [SAMPLE_WIDTH+1:0] sq_t;
  logic [POW_W-1:0]        power;
  logic [SUM_W:0]          sum_add;
  logic [SUM_W-1:0]        sum_upd;
  logic [RATE_W:0]         ft;
  logic [MAG_W-1:0]        mag;
  logic [RATE_W+BIN_W+3:0] freq_full;
  logic                    root_start, mag_done, band_done;
  logic [ROOT_W-1:0]       mag_root, band_root;
  reg_idx_t                reg_sel;

  smpb_isqrt u_mag_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (SUM_W'(power)),
    .done  (mag_done),
    .root  (mag_root)
  );

  smpb_isqrt u_band_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (sum_upd),
    .done  (band_done),
    .root  (band_root)
  );

  always_comb begin
    if (bins_log2_r == '0) begin
      eff_l = LOG_W'(1);
    end else if (bins_log2_r > LOG_W'(MAX_BINS_LOG2)) begin
      eff_l = LOG_W'(MAX_BINS_LOG2);
    end else begin
      eff_l = bins_log2_r;
    end
    n_full   = (BIN_W + 1)'(1) << eff_l;
    n_m1     = BIN_W'(n_full - 1'b1);
    n_half   = BIN_W'(n_full >> 1);
    band_ok  = (band_first_r <= band_last_r) && (band_last_r <= n_m1);
    band_in  = band_ok && (idx_r >= band_first_r) && (idx_r <= band_last_r);
    sq_t     = {1'b0, hi_r} + (ma_sr[0] ? {2'b00, a_r} : '0) +
               (mb_sr[0] ? {2'b00, b_r} : '0);
    power    = POW_W'({hi_r, lo_r});
    sum_add  = {1'b0, sum_r} + (SUM_W + 1)'(power);
    sum_upd  = sum_r;
    if (band_in) begin
      sum_upd = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end
    mag       = mag_root[MAG_W-1:0];
    peak_hit  = (idx_r != '0) && (idx_r <= n_half) && (mag > best_mag_r);
    ft        = {1'b0, fhi_r} + (fm_sr[0] ? {1'b0, rate_r} : '0);
    freq_full = {fhi_r, flo_r, 4'b0000} >> eff_l;
    can_load  = !out_valid_r || out_ready;
    root_start = (state_r == ST_SUM);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ma_nxt        = ma_sr;
    mb_nxt        = mb_sr;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    bin_cnt_nxt   = bin_cnt_r;
    best_bin_nxt  = best_bin_r;
    best_mag_nxt  = best_mag_r;
    sum_nxt       = sum_r;
    fm_nxt        = fm_sr;
    fhi_nxt       = fhi_r;
    flo_nxt       = flo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_idx_nxt     = o_idx_r;
    o_mag_nxt     = o_mag_r;
    o_end_nxt     = o_end_r;
    o_pbin_nxt    = o_pbin_r;
    o_pmag_nxt    = o_pmag_r;
    o_freq_nxt    = o_freq_r;
    o_band_nxt    = o_band_r;
    o_bval_nxt    = o_bval_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_nxt    = in_re_part[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_re_part)
                                                : in_re_part;
          b_nxt    = in_im_part[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_im_part)
                                                : in_im_part;
          ma_nxt   = a_nxt;
          mb_nxt   = b_nxt;
          hi_nxt   = '0;
          lo_nxt   = '0;
          cnt_nxt  = '0;
          idx_nxt  = bin_cnt_r;
          last_nxt = (bin_cnt_r >= n_m1);
          bin_cnt_nxt = last_nxt ? '0 : bin_cnt_r + 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        hi_nxt  = sq_t[SAMPLE_WIDTH+1:1];
        lo_nxt  = {sq_t[0], lo_r[SAMPLE_WIDTH-1:1]};
        ma_nxt  = {1'b0, ma_sr[SAMPLE_WIDTH-1:1]};
        mb_nxt  = {1'b0, mb_sr[SAMPLE_WIDTH-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(SAMPLE_WIDTH - 1)) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_nxt   = sum_upd;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (band_done) begin
          if (peak_hit) begin
            best_bin_nxt = idx_r;
            best_mag_nxt = mag;
          end
          fm_nxt  = best_bin_nxt;
          fhi_nxt = '0;
          flo_nxt = '0;
          cnt_nxt = '0;
          state_nxt = last_r ? ST_FREQ : ST_EMIT;
        end
      end
      ST_FREQ: begin
        fhi_nxt = ft[RATE_W:1];
        flo_nxt = {ft[0], flo_r[BIN_W-1:1]};
        fm_nxt  = {1'b0, fm_sr[BIN_W-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(BIN_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          o_idx_nxt     = idx_r;
          o_mag_nxt     = mag;
          o_end_nxt     = last_r;
          o_pbin_nxt    = last_r ? best_bin_r : '0;
          o_pmag_nxt    = last_r ? best_mag_r : '0;
          o_freq_nxt    = last_r ? FREQ_W'(freq_full) : '0;
          o_band_nxt    = (last_r && band_ok) ? band_root : '0;
          o_bval_nxt    = last_r && band_ok;
          if (last_r) begin
            best_bin_nxt = '0;
            best_mag_nxt = '0;
            sum_nxt      = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bin_cnt_r   <= '0;
      best_bin_r  <= '0;
      best_mag_r  <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bin_cnt_r   <= bin_cnt_nxt;
      best_bin_r  <= best_bin_nxt;
      best_mag_r  <= best_mag_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    ma_sr    <= ma_nxt;
    mb_sr    <= mb_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
    fm_sr    <= fm_nxt;
    fhi_r    <= fhi_nxt;
    flo_r    <= flo_nxt;
    o_idx_r  <= o_idx_nxt;
    o_mag_r  <= o_mag_nxt;
    o_end_r  <= o_end_nxt;
    o_pbin_r <= o_pbin_nxt;
    o_pmag_r <= o_pmag_nxt;
    o_freq_r <= o_freq_nxt;
    o_band_r <= o_band_nxt;
    o_bval_r <= o_bval_nxt;
  end

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_log2_r  <= LOG_W'(10);
      rate_r       <= RATE_W'(48000);
      band_first_r <= '0;
      band_last_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BINS_LOG2:   bins_log2_r  <= pwdata[LOG_W-1:0];
        REG_SAMPLE_RATE: rate_r       <= pwdata[RATE_W-1:0];
        REG_BAND_FIRST:  band_first_r <= pwdata[BIN_W-1:0];
        REG_BAND_LAST:   band_last_r  <= pwdata[BIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BINS_LOG2:   prdata = DATA_W'(bins_log2_r);
      REG_SAMPLE_RATE: prdata = DATA_W'(rate_r);
      REG_BAND_FIRST:  prdata = DATA_W'(band_first_r);
      REG_BAND_LAST:   prdata = DATA_W'(band_last_r);
      default:         prdata = '0;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_bin_index      = o_idx_r;
  assign out_bin_magnitude  = o_mag_r;
  assign out_frame_end      = o_end_r;
  assign out_peak_bin       = o_pbin_r;
  assign out_peak_magnitude = o_pmag_r;
  assign out_peak_freq_q4   = o_freq_r;
  assign out_band_strength  = o_band_r;
  assign out_band_valid     = o_bval_r;

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |->
      out_peak_bin == '0 && out_peak_magnitude == '0 && out_peak_freq_q4 == '0 &&
      out_band_strength == '0 && !out_band_valid)
    else $error("Summary fields set on a transfer that does not end a frame.");

  a_band_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_band_valid |-> out_band_strength == '0)
    else $error("Band strength reported for an invalid band.");

  a_peak_pair: assert property (@(posedge clk) disable iff (!rst_n)
    best_mag_r == '0 |-> best_bin_r == '0)
    else $error("Peak bin set while the peak magnitude is zero.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Second input transfer taken while a bin is in work.");

  a_roots_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    mag_done == band_done)
    else $error("Magnitude and band root units finished on different cycles.");

endmodule
